FILE: src/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int TCW_ROWS = 25;
   localparam int TCW_COLS = 80;

   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int CROW_W = 5;
   localparam int CCOL_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } tcw_cmd_type;

   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic sweep_clear;
      logic sweep_copy;
      logic load_rsp;
   } tcw_ctrl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_clear;
      logic is_scroll;
      logic clear_last;
      logic copy_last;
   } tcw_stat_type;

endpackage
`default_nettype wire

FILE: src/tcw_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_req_if
// Command channel: valid/ready with one command word.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [CHAR_W-1:0] char_code;
   logic [CROW_W-1:0] cell_row;
   logic [CCOL_W-1:0] cell_col;
   logic              last_of_write;

   modport source (output valid, cmd, char_code, cell_row, cell_col, last_of_write,
                   input ready);
   modport sink   (input valid, cmd, char_code, cell_row, cell_col, last_of_write,
                   output ready);
endinterface
`default_nettype wire

FILE: src/tcw_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Result channel: valid/ready with one result word.
// ----------------------------------------------------------------------------
interface tcw_rsp_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CROW_W-1:0] cursor_row;
   logic [CCOL_W-1:0] cursor_col;
   logic [CHAR_W-1:0] cell_char;
   logic              scrolled;
   logic              write_done;

   modport source (output valid, cursor_row, cursor_col, cell_char, scrolled, write_done,
                   input ready);
   modport sink   (input valid, cursor_row, cursor_col, cell_char, scrolled, write_done,
                   output ready);
endinterface
`default_nettype wire

FILE: src/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: accepts one word, runs clear or scroll sweeps, hands out result.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire tcw_stat_type stat,
   output tcw_ctrl_type      ctrl
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCROLL,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   assign ctrl.accept      = accept;
   assign ctrl.sweep_clear = (state_ff == ST_INIT) || (state_ff == ST_CLEAR);
   assign ctrl.sweep_copy  = (state_ff == ST_SCROLL);
   assign ctrl.load_rsp    = load;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (stat.is_clear)       state_in = ST_CLEAR;
               else if (stat.is_scroll) state_in = ST_SCROLL;
               else                     state_in = ST_RESP;
            end
         end
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_RESP;
         end
         ST_SCROLL: begin
            if (stat.copy_last) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: src/tcw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, screen store, sweep counter and result register.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; #(
   parameter int ROWS = TCW_ROWS,
   parameter int COLS = TCW_COLS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tcw_ctrl_type      ctrl,
   output tcw_stat_type           stat,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [CHAR_W-1:0] req_char_code,
   input  wire logic [CROW_W-1:0] req_cell_row,
   input  wire logic [CCOL_W-1:0] req_cell_col,
   input  wire logic              req_last_of_write,
   output logic      [CROW_W-1:0] rsp_cursor_row,
   output logic      [CCOL_W-1:0] rsp_cursor_col,
   output logic      [CHAR_W-1:0] rsp_cell_char,
   output logic                   rsp_scrolled,
   output logic                   rsp_write_done
);

   localparam int DEPTH    = ROWS * COLS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int COL_W    = $clog2(COLS);
   localparam int COPY_LEN = (ROWS - 1) * COLS;

   localparam logic [ADDR_W-1:0] ADDR_END   = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(COPY_LEN);
   localparam logic [ADDR_W-1:0] COL_STRIDE = ADDR_W'(COLS);
   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              copy_pend_ff, copy_pend_in;
   logic              hit_ff, scr_ff, last_ff;

   logic [CROW_W-1:0] rsp_row_ff;
   logic [CCOL_W-1:0] rsp_col_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_scr_ff, rsp_last_ff;

   logic              is_put, is_cr, is_lf, is_read, read_hit, put_scroll;
   logic [ROW_W-1:0]  step_row, wrap_row, next_row;
   logic [COL_W-1:0]  step_col, wrap_col, next_col;
   logic [31:0]       row_wide, col_wide;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CHAR_W-1:0] wr_data, rd_data;

   assign is_put  = (req_cmd == CMD_PUT);
   assign is_read = (req_cmd == CMD_READ);
   assign is_cr   = (req_char_code == CH_CR);
   assign is_lf   = (req_char_code == CH_LF);
   assign read_hit = is_read && (int'(req_cell_row) < ROWS) && (int'(req_cell_col) < COLS);

   // cursor step: newline or advance, then wrap, then scroll back one row
   always_comb begin
      step_row = row_ff;
      step_col = col_ff + 1'b1;
      if (is_lf) begin
         step_row = row_ff + 1'b1;
         step_col = '0;
      end
      wrap_row = step_row;
      wrap_col = step_col;
      if (step_col >= COL_LAST) begin
         wrap_row = step_row + 1'b1;
         wrap_col = '0;
      end
      put_scroll = (wrap_row >= ROW_LAST);
      next_row   = put_scroll ? wrap_row - 1'b1 : wrap_row;
      next_col   = put_scroll ? '0 : wrap_col;
   end

   assign stat.is_clear   = (req_cmd == CMD_CLEAR);
   assign stat.is_scroll  = is_put && !is_cr && put_scroll;
   assign stat.clear_last = (cnt_ff == ADDR_END);
   assign stat.copy_last  = (cnt_ff == COPY_END);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (ctrl.accept) begin
         case (req_cmd)
            CMD_PUT: begin
               if (!is_cr) begin
                  row_in = next_row;
                  col_in = next_col;
               end
            end
            CMD_CLEAR: begin
               row_in = '0;
               col_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.accept)                            cnt_in = '0;
      else if (ctrl.sweep_clear || ctrl.sweep_copy) cnt_in = cnt_ff + 1'b1;
   end

   assign copy_pend_in = ctrl.sweep_copy && (cnt_ff != COPY_END);

   // store ports: character write, clear fill or row copy
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(row_ff) * COL_STRIDE + ADDR_W'(col_ff);
      wr_data = req_char_code;
      if (ctrl.accept) begin
         wr_en = is_put && !is_cr && !is_lf;
      end else if (ctrl.sweep_clear) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_data = CH_SPACE;
      end else if (copy_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff - 1'b1;
         wr_data = rd_data;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ADDR_W'(req_cell_row) * COL_STRIDE + ADDR_W'(req_cell_col);
      if (ctrl.accept) begin
         rd_en = read_hit;
      end else if (ctrl.sweep_copy) begin
         rd_en   = (cnt_ff != COPY_END);
         rd_addr = cnt_ff + COL_STRIDE;
      end
   end

   tcw_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (DEPTH)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         copy_pend_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         copy_pend_ff <= copy_pend_in;
      end
   end

   assign row_wide = 32'(row_ff);
   assign col_wide = 32'(col_ff);

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         hit_ff  <= read_hit;
         scr_ff  <= stat.is_scroll;
         last_ff <= req_last_of_write;
      end
      if (ctrl.load_rsp) begin
         rsp_row_ff  <= row_wide[CROW_W-1:0];
         rsp_col_ff  <= col_wide[CCOL_W-1:0];
         rsp_char_ff <= hit_ff ? rd_data : '0;
         rsp_scr_ff  <= scr_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_scrolled   = rsp_scr_ff;
   assign rsp_write_done = rsp_last_ff;

endmodule
`default_nettype wire

FILE: src/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// Put, carriage return and read words go through the result state into the output register.
// A scrolling put adds a row copy through the single store write port.
// A clear adds a space fill, one cell per cycle.
// No new word is taken until the last result is loaded; one store write port sets the sweeps.
// Reset: synchronous; afterwards the whole store is filled with spaces
// before the first word is taken. Cursor homes to row 0, column 0.
// ----------------------------------------------------------------------------
// text_console_writer
// Character screen store with cursor, wrap and scroll, driven by command words.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
   parameter int ROWS = TCW_ROWS,
   parameter int COLS = TCW_COLS
) (
   input wire logic  clock,
   input wire logic  reset,
   tcw_req_if.sink   req_bus,
   tcw_rsp_if.source rsp_bus
);

   // Controller and datapath talk only through these two bundles.
   tcw_ctrl_type ctrl;
   tcw_stat_type stat;

   // Controller: takes one word in idle, steps the clear or copy sweep,
   // then parks the result in the output register while the next word may wait.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // Datapath: cursor registers, the screen store and the result word.
   // Ordinary characters are written in the accept cycle without a read.
   tcw_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_cmd           (req_bus.cmd),
      .req_char_code     (req_bus.char_code),
      .req_cell_row      (req_bus.cell_row),
      .req_cell_col      (req_bus.cell_col),
      .req_last_of_write (req_bus.last_of_write),
      .rsp_cursor_row    (rsp_bus.cursor_row),
      .rsp_cursor_col    (rsp_bus.cursor_col),
      .rsp_cell_char     (rsp_bus.cell_char),
      .rsp_scrolled      (rsp_bus.scrolled),
      .rsp_write_done    (rsp_bus.write_done)
   );

endmodule
`default_nettype wire

FILE: test/text_console_writer_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the command and result channels of the text console writer. It
// keeps its own screen and cursor, works out the reply to every accepted
// command word and compares each reply word with the oldest one awaited.
// ----------------------------------------------------------------------------
module text_console_writer_checker import tcw_pkg::*; #(
   parameter int ROWS = TCW_ROWS,
   parameter int COLS = TCW_COLS
) (
   input  wire logic clock,
   input  wire logic reset,
   tcw_req_if        req_bus,
   tcw_rsp_if        rsp_bus,
   output int        fail_count,
   output int        pending_words
);

   typedef struct packed {
      logic [CROW_W-1:0] cursor_row;
      logic [CCOL_W-1:0] cursor_col;
      logic [CHAR_W-1:0] cell_char;
      logic              scrolled;
      logic              write_done;
   } console_reply_type;

   logic [CHAR_W-1:0] screen [ROWS][COLS];
   int                cur_row;
   int                cur_col;
   console_reply_type awaited_replies [$];
   console_reply_type observed;

   function automatic void blank_screen();
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            screen[r][c] = CH_SPACE;
         end
      end
      cur_row = 0;
      cur_col = 0;
   endfunction

   // Apply one command word to the screen and cursor, return the reply it earns.
   function automatic console_reply_type apply_command(input logic [CMD_W-1:0]  cmd,
                                                       input logic [CHAR_W-1:0] ch,
                                                       input logic [CROW_W-1:0] row,
                                                       input logic [CCOL_W-1:0] col,
                                                       input logic              last);
      console_reply_type reply;
      reply            = '0;
      reply.write_done = last;
      if (cmd == CMD_PUT) begin
         if (ch != CH_CR) begin
            if (ch == CH_LF) begin
               cur_row++;
               cur_col = 0;
            end else begin
               if (cur_row < ROWS && cur_col < COLS) screen[cur_row][cur_col] = ch;
               cur_col++;
            end
            if (cur_col >= COLS - 1) begin
               cur_col = 0;
               cur_row++;
            end
            // scroll: rows move up by one, the bottom row keeps its contents
            if (cur_row >= ROWS - 1) begin
               cur_col = 0;
               cur_row--;
               for (int r = 0; r < ROWS - 1; r++) begin
                  for (int c = 0; c < COLS; c++) begin
                     screen[r][c] = screen[r + 1][c];
                  end
               end
               reply.scrolled = 1'b1;
            end
         end
      end else if (cmd == CMD_CLEAR) begin
         blank_screen();
      end else if (cmd == CMD_READ) begin
         if (row < ROWS && col < COLS) reply.cell_char = screen[row][col];
      end
      reply.cursor_row = cur_row[CROW_W-1:0];
      reply.cursor_col = cur_col[CCOL_W-1:0];
      return reply;
   endfunction

   function automatic void check_field(input string field,
                                       input logic [CHAR_W-1:0] want,
                                       input logic [CHAR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         blank_screen();
         awaited_replies.delete();
         fail_count = 0;
      end else begin
         // a reply never belongs to a command taken at the same edge: pop first
         if (rsp_bus.valid && rsp_bus.ready) begin
            observed.cursor_row = rsp_bus.cursor_row;
            observed.cursor_col = rsp_bus.cursor_col;
            observed.cell_char  = rsp_bus.cell_char;
            observed.scrolled   = rsp_bus.scrolled;
            observed.write_done = rsp_bus.write_done;
            if (awaited_replies.size() == 0) begin
               $display("%0t: unexpected reply word: expected none, actual %h",
                        $time, observed);
               fail_count++;
            end else begin
               console_reply_type want;
               want = awaited_replies.pop_front();
               check_field("cursor_row", CHAR_W'(want.cursor_row),
                           CHAR_W'(observed.cursor_row));
               check_field("cursor_col", CHAR_W'(want.cursor_col),
                           CHAR_W'(observed.cursor_col));
               check_field("cell_char",  want.cell_char,  observed.cell_char);
               check_field("scrolled",   CHAR_W'(want.scrolled),
                           CHAR_W'(observed.scrolled));
               check_field("write_done", CHAR_W'(want.write_done),
                           CHAR_W'(observed.write_done));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            awaited_replies.push_back(apply_command(req_bus.cmd, req_bus.char_code,
                                                    req_bus.cell_row, req_bus.cell_col,
                                                    req_bus.last_of_write));
         end
      end
      pending_words <= awaited_replies.size();
   end

endmodule
`default_nettype wire

FILE: test/text_console_writer_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Drives command words into the text console writer with random gaps and
// random back-pressure on the reply side. A short directed opening covers
// the byte extremes, carriage return, newline, clear, unused commands and
// out-of-range reads; the bulk is random write requests (lines of text with
// newlines, wraps and scrolls) mixed with reads and noise. The checker beside
// the block predicts and compares every reply word.
// ----------------------------------------------------------------------------
module text_console_writer_tb import tcw_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_WORDS    = 1250;
   localparam int HOLD_OFF_AT     = 300;   // words sent before the long reply stall
   localparam int PAUSE_AT        = 700;   // words sent before the sender waits for all replies
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 50;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_words;
   int   words_sent;
   bit   hold_off_due;
   bit   hold_off_armed;
   bit   pause_done;
   bit   eager;            // when set, the sender offers words back to back

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_writer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   text_console_writer_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run, where every word would sweep the store.
   initial begin
      #100_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Mostly back to back, some short gaps and now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (eager || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Newlines and carriage returns often enough to hit the line logic, else
   // printable text with a good share of arbitrary bytes.
   function automatic logic [CHAR_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return CH_LF;
      if (r < 11) return CH_CR;
      if (r < 60) return CHAR_W'($urandom_range(8'h20, 8'h7E));
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // Offer one word and hold it until the block takes it. Keep valid high
   // across back-to-back words so that it gets a single assignment per edge.
   task automatic send_word(input logic [CMD_W-1:0]  cmd,
                            input logic [CHAR_W-1:0] ch,
                            input logic [CROW_W-1:0] row,
                            input logic [CCOL_W-1:0] col,
                            input logic              last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= cmd;
      req_bus.char_code     <= ch;
      req_bus.cell_row      <= row;
      req_bus.cell_col      <= col;
      req_bus.last_of_write <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // carriage returns and unused commands leave the block untouched: do not count them
      if (!((cmd == CMD_PUT && ch == CH_CR) || cmd == CMD_UNUSED)) words_sent++;
   endtask

   // Wait one edge first so that the checker's count covers the last word taken.
   task automatic wait_for_replies();
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic send_read(input bit in_range);
      logic [CROW_W-1:0] row;
      logic [CCOL_W-1:0] col;
      row = in_range ? CROW_W'($urandom_range(0, TCW_ROWS - 1))
                     : CROW_W'($urandom_range(0, 31));
      col = in_range ? CCOL_W'($urandom_range(0, TCW_COLS - 1))
                     : CCOL_W'($urandom_range(0, 127));
      send_word(CMD_READ, CHAR_W'($urandom_range(0, 255)), row, col,
                1'($urandom_range(0, 1)));
   endtask

   // Command side: reset, directed opening, then random traffic.
   initial begin
      int r;
      int len;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.cmd           <= CMD_PUT;
      req_bus.char_code     <= '0;
      req_bus.cell_row      <= '0;
      req_bus.cell_col      <= '0;
      req_bus.last_of_write <= 1'b0;
      words_sent     = 0;
      hold_off_due   = 1'b0;
      hold_off_armed = 1'b0;
      pause_done     = 1'b0;
      eager          = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The fresh store reads back as spaces, including the far corner.
      send_word(CMD_READ, 8'h00, 5'd0, 7'd0, 1'b0);
      send_word(CMD_READ, 8'h00, CROW_W'(TCW_ROWS - 1), CCOL_W'(TCW_COLS - 1), 1'b1);
      // Reads past the screen answer zero.
      send_word(CMD_READ, 8'hFF, 5'h1F, 7'h7F, 1'b0);
      send_word(CMD_READ, 8'h00, CROW_W'(TCW_ROWS), 7'd0, 1'b0);
      send_word(CMD_READ, 8'h00, 5'd0, CCOL_W'(TCW_COLS), 1'b0);
      // Byte extremes, then a carriage return that must change nothing.
      send_word(CMD_PUT, 8'h00, 5'd0, 7'd0, 1'b0);
      send_word(CMD_PUT, 8'hFF, 5'h1F, 7'h7F, 1'b0);
      send_word(CMD_PUT, CH_CR, 5'd0, 7'd0, 1'b1);
      send_word(CMD_READ, 8'h00, 5'd0, 7'd0, 1'b0);
      send_word(CMD_READ, 8'h00, 5'd0, 7'd1, 1'b0);
      send_word(CMD_READ, 8'h00, 5'd0, 7'd2, 1'b1);
      // Unused command: no effect, zero cell.
      send_word(CMD_UNUSED, 8'hFF, 5'h1F, 7'h7F, 1'b1);
      send_word(CMD_PUT, CH_LF, 5'd0, 7'd0, 1'b0);
      send_word(CMD_PUT, CH_SPACE, 5'd0, 7'd0, 1'b1);
      send_word(CMD_READ, 8'h00, 5'd1, 7'd0, 1'b0);
      // Clear, then check the home cell is blank again.
      send_word(CMD_CLEAR, 8'hA5, 5'h15, 7'h55, 1'b1);
      send_word(CMD_READ, 8'h00, 5'd0, 7'd0, 1'b0);

      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 19) == 0) eager = ~eager;
         if (!hold_off_armed && words_sent >= HOLD_OFF_AT) begin
            hold_off_armed = 1'b1;
            hold_off_due   = 1'b1;
         end
         if (!pause_done && words_sent >= PAUSE_AT) begin
            pause_done = 1'b1;
            req_bus.valid <= 1'b0;
            wait_for_replies();
         end
         r = $urandom_range(0, 99);
         if (r < 60) begin
            // one write request: a short line mostly, a long wrapping one sometimes
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               send_word(CMD_PUT, pick_char(), CROW_W'($urandom_range(0, 31)),
                         CCOL_W'($urandom_range(0, 127)), (i == len - 1));
            end
         end else if (r < 85) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) send_read($urandom_range(0, 9) != 0);
         end else if (r < 87) begin
            // run of newlines: long enough runs reach the bottom and scroll repeatedly
            len = $urandom_range(5, 26);
            for (int i = 0; i < len; i++) begin
               send_word(CMD_PUT, CH_LF, 5'd0, 7'd0, (i == len - 1));
            end
         end else if (r < 89) begin
            send_word(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                      CROW_W'($urandom_range(0, 31)), CCOL_W'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)));
         end else if (r < 92) begin
            send_word(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)),
                      CROW_W'($urandom_range(0, 31)), CCOL_W'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)));
         end else begin
            // stray put with an arbitrary byte and an arbitrary end mark
            send_word(CMD_PUT, CHAR_W'($urandom_range(0, 255)),
                      CROW_W'($urandom_range(0, 31)), CCOL_W'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)));
         end
      end

      // Drop valid, let every reply arrive, then give stray words a chance to show.
      req_bus.valid <= 1'b0;
      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Reply side: alternate quiet stretches with stretches of random stalls,
   // and once hold ready low long enough for the block to back up.
   initial begin
      int stall_left;
      int stretch_left;
      int hold_count;
      bit busy;
      rsp_bus.ready <= 1'b0;
      stall_left   = 0;
      stretch_left = 0;
      busy         = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++) @(posedge clock);
         end
         if (stretch_left == 0) begin
            busy         = ($urandom_range(0, 2) != 0);
            stretch_left = $urandom_range(50, 300);
         end
         stretch_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (busy && $urandom_range(0, 3) == 0) begin
            // mostly short stalls, a few long ones
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(7, 39);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

endmodule
`default_nettype wire

FILE: files.f
src/tcw_pkg.sv
src/tcw_req_if.sv
src/tcw_rsp_if.sv
src/tcw_ram.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_writer.sv
test/text_console_writer_checker.sv
test/text_console_writer_tb.sv
